### sv/smfr_pkg.sv
// shared types, codes and constants for the sound meter frame receiver
package smfr_pkg;

   // frame layout
   localparam int unsigned FRAME_LEN = 10;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned LEVEL_W = 17;

   // byte positions within a frame
   localparam logic [COUNT_W-1:0] POS_HDR0 = 4'd0;
   localparam logic [COUNT_W-1:0] POS_HDR1 = 4'd1;
   localparam logic [COUNT_W-1:0] POS_MODE = 4'd2;
   localparam logic [COUNT_W-1:0] POS_DIGIT_FIRST = 4'd3;
   localparam logic [COUNT_W-1:0] POS_DIGIT_LAST = 4'd7;
   localparam logic [COUNT_W-1:0] POS_MEAS = 4'd8;
   localparam logic [COUNT_W-1:0] POS_CHECKSUM = 4'd9;

   // byte values
   localparam logic [7:0] BYTE_HDR0 = 8'h08;
   localparam logic [7:0] BYTE_HDR1 = 8'h04;
   localparam logic [7:0] BYTE_MEAS = 8'h01;
   localparam logic [7:0] BYTE_DATA_READY = 8'h10;
   localparam logic [7:0] BYTE_COMMAND = 8'h20;
   localparam logic [7:0] DIGIT_MAX = 8'h09;

   // high mode nibble values
   localparam logic [3:0] MODE_NORMAL = 4'h1;
   localparam logic [3:0] MODE_HOLD = 4'h2;

   // frequency weighting codes
   localparam logic [1:0] FW_A = 2'd0;
   localparam logic [1:0] FW_C = 2'd1;
   localparam logic [1:0] FW_FLAT = 2'd2;

   // time weighting codes
   localparam logic [1:0] TW_FAST = 2'd0;
   localparam logic [1:0] TW_SLOW = 2'd1;
   localparam logic [1:0] TW_NONE = 2'd2;

   typedef enum logic [1:0] {
      KIND_COMMAND = 2'd0,
      KIND_READING = 2'd1,
      KIND_REJECT  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_HEADER   = 3'd1,
      ERR_MEAS     = 3'd2,
      ERR_CHECKSUM = 3'd3,
      ERR_MODE     = 3'd4,
      ERR_CONFIG   = 3'd5
   } err_type;

   // one result item
   typedef struct packed {
      kind_type             kind;
      logic [7:0]           tx_byte;
      logic [LEVEL_W-1:0]   level_tenths;
      logic                 hold;
      logic [1:0]           freq_weight;
      logic [1:0]           time_weight;
      logic                 long_term_avg;
      logic                 over_alarm;
      err_type              error_code;
   } rsp_data_type;

   // frame tracker status seen by the checker
   typedef struct packed {
      logic                 cmd;
      logic                 last;
      logic                 hdr_ok;
      logic                 meas_ok;
      logic [7:0]           sum;
      logic [LEVEL_W-1:0]   level;
      logic [7:0]           mode;
   } frame_status_type;

endpackage

### sv/smfr_if.sv
// valid/ready channel interfaces for received bytes and results
interface smfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface smfr_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         kind;
   logic [7:0]                         tx_byte;
   logic [smfr_pkg::LEVEL_W-1:0]       level_tenths;
   logic                               hold;
   logic [1:0]                         freq_weight;
   logic [1:0]                         time_weight;
   logic                               long_term_avg;
   logic                               over_alarm;
   logic [2:0]                         error_code;

   modport source (
      output valid, output kind, output tx_byte, output level_tenths, output hold,
      output freq_weight, output time_weight, output long_term_avg,
      output over_alarm, output error_code, input ready
   );
   modport sink (
      input valid, input kind, input tx_byte, input level_tenths, input hold,
      input freq_weight, input time_weight, input long_term_avg,
      input over_alarm, input error_code, output ready
   );
endinterface

### sv/smfr_tracker.sv
// frame tracker: idle/collect control, byte count and running frame checks
module smfr_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        byte_valid,
   input  logic [7:0]                  byte_data,
   output smfr_pkg::frame_status_type  status
);

   logic                                  collecting_ff, collecting_in;
   logic [smfr_pkg::COUNT_W-1:0]          count_ff, count_in;
   logic                                  hdr_ok_ff, hdr_ok_in;
   logic                                  meas_ok_ff, meas_ok_in;
   logic [7:0]                            sum_ff, sum_in;
   logic [smfr_pkg::LEVEL_W-1:0]          level_ff, level_in;
   logic [7:0]                            mode_ff, mode_in;
   logic                                  cmd, last, in_digits;

   // current byte classification
   assign cmd  = !collecting_ff && (byte_data == smfr_pkg::BYTE_DATA_READY);
   assign last = collecting_ff && (count_ff == smfr_pkg::POS_CHECKSUM);
   assign in_digits = (count_ff >= smfr_pkg::POS_DIGIT_FIRST) &&
                      (count_ff <= smfr_pkg::POS_DIGIT_LAST);

   // next state of control and running values
   always_comb begin
      collecting_in = collecting_ff;
      count_in = count_ff;
      hdr_ok_in = hdr_ok_ff;
      meas_ok_in = meas_ok_ff;
      sum_in = sum_ff;
      level_in = level_ff;
      mode_in = mode_ff;
      if (cmd) begin
         collecting_in = 1'b1;
         count_in = '0;
         sum_in = '0;
         level_in = '0;
      end else if (collecting_ff) begin
         if (last) begin
            collecting_in = 1'b0;
            count_in = '0;
         end else begin
            count_in = count_ff + smfr_pkg::COUNT_W'(1);
            sum_in = sum_ff + byte_data;
         end
         if (count_ff == smfr_pkg::POS_HDR0) begin
            hdr_ok_in = (byte_data == smfr_pkg::BYTE_HDR0);
         end
         if (count_ff == smfr_pkg::POS_HDR1) begin
            hdr_ok_in = hdr_ok_ff && (byte_data == smfr_pkg::BYTE_HDR1);
         end
         if (count_ff == smfr_pkg::POS_MODE) begin
            mode_in = byte_data;
         end
         if (count_ff == smfr_pkg::POS_MEAS) begin
            meas_ok_in = (byte_data == smfr_pkg::BYTE_MEAS);
         end
         // decimal accumulation, bytes above nine are skipped
         if (in_digits && (byte_data <= smfr_pkg::DIGIT_MAX)) begin
            level_in = smfr_pkg::LEVEL_W'(level_ff * smfr_pkg::LEVEL_W'(10)) +
                       {{(smfr_pkg::LEVEL_W-4){1'b0}}, byte_data[3:0]};
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         count_ff <= '0;
      end else if (byte_valid) begin
         collecting_ff <= collecting_in;
         count_ff <= count_in;
      end
   end

   // running frame values
   always_ff @(posedge clock) begin
      if (byte_valid) begin
         hdr_ok_ff <= hdr_ok_in;
         meas_ok_ff <= meas_ok_in;
         sum_ff <= sum_in;
         level_ff <= level_in;
         mode_ff <= mode_in;
      end
   end

   assign status.cmd = cmd;
   assign status.last = last;
   assign status.hdr_ok = hdr_ok_ff;
   assign status.meas_ok = meas_ok_ff;
   assign status.sum = sum_ff;
   assign status.level = level_ff;
   assign status.mode = mode_ff;

endmodule

### sv/smfr_check.sv
// frame checker and mode decoder, builds the result item
module smfr_check (
   input  smfr_pkg::frame_status_type  status,
   input  logic [7:0]                  byte_data,
   output logic                        emit,
   output smfr_pkg::rsp_data_type      result
);

   logic [3:0]       hi, lo;
   logic [1:0]       fw, tw;
   logic             lat, ova, cfg_bad;

   assign hi = status.mode[7:4];
   assign lo = status.mode[3:0];
   assign emit = status.cmd || status.last;

   // low mode nibble decode
   always_comb begin
      fw = smfr_pkg::FW_A;
      tw = smfr_pkg::TW_FAST;
      lat = 1'b0;
      ova = 1'b0;
      cfg_bad = 1'b0;
      unique case (lo)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: begin
            fw = lo[2:1];
            tw = {1'b0, lo[0]};
         end
         4'd6, 4'd7: begin
            ova = 1'b1;
            tw = {1'b0, lo[0]};
         end
         4'd8, 4'd9, 4'd10, 4'd11: begin
            lat = 1'b1;
            tw = {1'b0, lo[1]};
         end
         4'd12, 4'd13: begin
            fw = smfr_pkg::FW_FLAT;
            tw = smfr_pkg::TW_NONE;
         end
         default: begin
            cfg_bad = 1'b1;
         end
      endcase
   end

   // checks in order, first failure wins
   always_comb begin
      result = '0;
      result.kind = smfr_pkg::KIND_REJECT;
      result.error_code = smfr_pkg::ERR_NONE;
      if (status.cmd) begin
         result.kind = smfr_pkg::KIND_COMMAND;
         result.tx_byte = smfr_pkg::BYTE_COMMAND;
      end else priority if (!status.hdr_ok) begin
         result.error_code = smfr_pkg::ERR_HEADER;
      end else if (!status.meas_ok) begin
         result.error_code = smfr_pkg::ERR_MEAS;
      end else if (status.sum != byte_data) begin
         result.error_code = smfr_pkg::ERR_CHECKSUM;
      end else if ((hi != smfr_pkg::MODE_NORMAL) && (hi != smfr_pkg::MODE_HOLD)) begin
         result.error_code = smfr_pkg::ERR_MODE;
      end else if (cfg_bad) begin
         result.error_code = smfr_pkg::ERR_CONFIG;
      end else begin
         result.kind = smfr_pkg::KIND_READING;
         result.level_tenths = status.level;
         result.hold = (hi == smfr_pkg::MODE_HOLD);
         result.freq_weight = fw;
         result.time_weight = tw;
         result.long_term_avg = lat;
         result.over_alarm = ova;
      end
   end

endmodule

### sv/sound_meter_frame_receiver_core.sv
// Sound meter frame receiver: takes one received byte per cycle. While idle, a data-ready
// byte 0x10 yields a command result (tx_byte 0x20) and starts a 10-byte frame; other idle
// bytes are dropped. The tenth byte yields a reading or a rejection with an error code.
// A byte goes through an input register and a result register, so a result is offered from
// the result register once the byte that causes it has passed the input register. One byte
// is taken every cycle; the input side stalls only while a result in the output register
// waits to be taken.
module sound_meter_frame_receiver_core (
   input  logic           clock,
   input  logic           reset,
   smfr_req_if.sink       req_chan,
   smfr_rsp_if.source     rsp_chan
);

   logic                          in_valid_ff;
   logic [7:0]                    in_byte_ff;
   logic                          out_valid_ff;
   smfr_pkg::rsp_data_type        out_data_ff;
   logic                          out_free, advance, emit;
   smfr_pkg::frame_status_type    status;
   smfr_pkg::rsp_data_type        result;

   // flow control
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign advance = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   smfr_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (advance),
      .byte_data  (in_byte_ff),
      .status     (status)
   );

   smfr_check u_check (
      .status    (status),
      .byte_data (in_byte_ff),
      .emit      (emit),
      .result    (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_data_ff <= result;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.kind = out_data_ff.kind;
   assign rsp_chan.tx_byte = out_data_ff.tx_byte;
   assign rsp_chan.level_tenths = out_data_ff.level_tenths;
   assign rsp_chan.hold = out_data_ff.hold;
   assign rsp_chan.freq_weight = out_data_ff.freq_weight;
   assign rsp_chan.time_weight = out_data_ff.time_weight;
   assign rsp_chan.long_term_avg = out_data_ff.long_term_avg;
   assign rsp_chan.over_alarm = out_data_ff.over_alarm;
   assign rsp_chan.error_code = out_data_ff.error_code;

endmodule

### sim/testbench.sv
// self-checking testbench for the sound meter frame receiver with a result scoreboard
module testbench;

   typedef logic [smfr_pkg::FRAME_LEN-1:0][7:0] frame_bytes_type;

   typedef enum {
      RX_STEADY,
      RX_HALF,
      RX_SPARSE,
      RX_TOGGLE
   } rx_pattern_type;

   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD = 300;
   localparam int HOLD_AFTER = 500;
   localparam int TAIL_CYCLES = 16;
   localparam int PLAN_ITEMS = 2000;

   // tracks frames as bytes are accepted and holds the expected results in order
   class meter_result_tracker;
      logic                         in_frame;
      logic [smfr_pkg::COUNT_W-1:0] bytes_seen;
      frame_bytes_type              frame_buf;
      smfr_pkg::rsp_data_type       expected_results[$];
      int                           mismatches;

      function new();
         in_frame = 1'b0;
         bytes_seen = '0;
         frame_buf = '0;
         mismatches = 0;
      endfunction

      // checks run in a fixed order, the first failure gives the error code
      function smfr_pkg::rsp_data_type decode_frame();
         smfr_pkg::rsp_data_type r;
         logic [7:0]   sum;
         int unsigned  level;
         logic [3:0]   hi;
         logic [3:0]   lo;
         r = '0;
         r.kind = smfr_pkg::KIND_REJECT;
         sum = '0;
         level = 0;
         for (int i = 0; i < smfr_pkg::POS_CHECKSUM; i++) sum += frame_buf[i];
         for (int i = int'(smfr_pkg::POS_DIGIT_FIRST); i <= smfr_pkg::POS_DIGIT_LAST; i++) begin
            // bytes above nine are not digits and are skipped
            if (frame_buf[i] <= smfr_pkg::DIGIT_MAX) level = level * 10 + 32'(frame_buf[i]);
         end
         hi = frame_buf[smfr_pkg::POS_MODE][7:4];
         lo = frame_buf[smfr_pkg::POS_MODE][3:0];
         if (frame_buf[smfr_pkg::POS_HDR0] != smfr_pkg::BYTE_HDR0 ||
             frame_buf[smfr_pkg::POS_HDR1] != smfr_pkg::BYTE_HDR1) begin
            r.error_code = smfr_pkg::ERR_HEADER;
            return r;
         end
         if (frame_buf[smfr_pkg::POS_MEAS] != smfr_pkg::BYTE_MEAS) begin
            r.error_code = smfr_pkg::ERR_MEAS;
            return r;
         end
         if (sum != frame_buf[smfr_pkg::POS_CHECKSUM]) begin
            r.error_code = smfr_pkg::ERR_CHECKSUM;
            return r;
         end
         if (hi != smfr_pkg::MODE_NORMAL && hi != smfr_pkg::MODE_HOLD) begin
            r.error_code = smfr_pkg::ERR_MODE;
            return r;
         end
         // low mode nibble decode
         if (lo <= 4'd5) begin
            r.freq_weight = lo[2:1];
            r.time_weight = {1'b0, lo[0]};
         end else if (lo <= 4'd7) begin
            r.over_alarm = 1'b1;
            r.time_weight = {1'b0, lo[0]};
         end else if (lo <= 4'd11) begin
            r.long_term_avg = 1'b1;
            r.time_weight = {1'b0, lo[1]};
         end else if (lo <= 4'd13) begin
            r.freq_weight = smfr_pkg::FW_FLAT;
            r.time_weight = smfr_pkg::TW_NONE;
         end else begin
            r.error_code = smfr_pkg::ERR_CONFIG;
            return r;
         end
         r.kind = smfr_pkg::KIND_READING;
         r.level_tenths = level[smfr_pkg::LEVEL_W-1:0];
         r.hold = (hi == smfr_pkg::MODE_HOLD);
         r.error_code = smfr_pkg::ERR_NONE;
         return r;
      endfunction

      // one accepted byte: idle bytes other than data ready cause nothing
      function void note_rx_byte(logic [7:0] b);
         smfr_pkg::rsp_data_type r;
         if (!in_frame) begin
            if (b == smfr_pkg::BYTE_DATA_READY) begin
               r = '0;
               r.kind = smfr_pkg::KIND_COMMAND;
               r.tx_byte = smfr_pkg::BYTE_COMMAND;
               expected_results.push_back(r);
               in_frame = 1'b1;
               bytes_seen = '0;
            end
         end else begin
            frame_buf[bytes_seen] = b;
            if (bytes_seen == smfr_pkg::POS_CHECKSUM) begin
               expected_results.push_back(decode_frame());
               in_frame = 1'b0;
               bytes_seen = '0;
            end else begin
               bytes_seen++;
            end
         end
      endfunction

      // one accepted result against the oldest expectation
      function void check_result(smfr_pkg::rsp_data_type got);
         smfr_pkg::rsp_data_type want;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, kind %0h error %0h", $time, got.kind,
                     got.error_code);
            mismatches++;
            return;
         end
         want = expected_results.pop_front();
         if (got !== want) begin
            $display("%0t: result mismatch, expected %0h, actual %0h", $time, want, got);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   idle_cycles = 0;
   int   rx_transfers = 0;
   logic long_hold_done = 1'b0;
   logic [7:0] rx_plan[$];
   meter_result_tracker tracker;

   smfr_req_if req_bus ();
   smfr_rsp_if rsp_bus ();

   sound_meter_frame_receiver_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // data-ready byte, then the frame with its checksum (optionally spoiled)
   task automatic queue_frame(frame_bytes_type f, logic [7:0] flip);
      logic [7:0] sum;
      sum = '0;
      for (int i = 0; i < smfr_pkg::POS_CHECKSUM; i++) sum += f[i];
      f[smfr_pkg::POS_CHECKSUM] = sum ^ flip;
      rx_plan.push_back(smfr_pkg::BYTE_DATA_READY);
      for (int i = 0; i < smfr_pkg::FRAME_LEN; i++) rx_plan.push_back(f[i]);
   endtask

   // mostly good frames with random content, the rest carry one fault each
   task automatic plan_random_frame();
      frame_bytes_type   f;
      logic [3:0]        hi;
      logic [3:0]        lo;
      logic [7:0]        flip;
      int                pick;
      smfr_pkg::err_type fault;
      hi = ($urandom_range(0, 1) == 1) ? smfr_pkg::MODE_HOLD : smfr_pkg::MODE_NORMAL;
      lo = 4'($urandom_range(0, 13));
      flip = '0;
      f = '0;
      f[smfr_pkg::POS_HDR0] = smfr_pkg::BYTE_HDR0;
      f[smfr_pkg::POS_HDR1] = smfr_pkg::BYTE_HDR1;
      f[smfr_pkg::POS_MEAS] = smfr_pkg::BYTE_MEAS;
      for (int i = int'(smfr_pkg::POS_DIGIT_FIRST); i <= smfr_pkg::POS_DIGIT_LAST; i++) begin
         if ($urandom_range(0, 9) < 7) f[i] = 8'($urandom_range(0, 9));
         else f[i] = 8'($urandom_range(0, 255));
      end
      pick = $urandom_range(0, 19);
      fault = (pick >= 1 && pick <= 5) ? smfr_pkg::err_type'(pick) : smfr_pkg::ERR_NONE;
      case (fault)
         smfr_pkg::ERR_HEADER: begin
            if ($urandom_range(0, 1) == 1) begin
               f[smfr_pkg::POS_HDR0] = smfr_pkg::BYTE_HDR0 ^ 8'($urandom_range(1, 255));
            end else begin
               f[smfr_pkg::POS_HDR1] = smfr_pkg::BYTE_HDR1 ^ 8'($urandom_range(1, 255));
            end
         end
         smfr_pkg::ERR_MEAS: begin
            f[smfr_pkg::POS_MEAS] = smfr_pkg::BYTE_MEAS ^ 8'($urandom_range(1, 255));
         end
         smfr_pkg::ERR_CHECKSUM: begin
            flip = 8'($urandom_range(1, 255));
         end
         smfr_pkg::ERR_MODE: begin
            hi = ($urandom_range(0, 3) == 0) ? 4'h0 : 4'($urandom_range(3, 15));
         end
         smfr_pkg::ERR_CONFIG: begin
            lo = 4'($urandom_range(14, 15));
         end
         default: begin
         end
      endcase
      f[smfr_pkg::POS_MODE] = {hi, lo};
      queue_frame(f, flip);
   endtask

   task automatic build_plan();
      frame_bytes_type f;
      // idle extremes are dropped
      rx_plan.push_back(8'h00);
      rx_plan.push_back(8'hff);
      // hold, flat with no time weighting, largest level
      f = '0;
      f[smfr_pkg::POS_HDR0] = smfr_pkg::BYTE_HDR0;
      f[smfr_pkg::POS_HDR1] = smfr_pkg::BYTE_HDR1;
      f[smfr_pkg::POS_MODE] = {smfr_pkg::MODE_HOLD, 4'd13};
      for (int i = int'(smfr_pkg::POS_DIGIT_FIRST); i <= smfr_pkg::POS_DIGIT_LAST; i++) begin
         f[i] = smfr_pkg::DIGIT_MAX;
      end
      f[smfr_pkg::POS_MEAS] = smfr_pkg::BYTE_MEAS;
      queue_frame(f, 8'h00);
      // data ready inside a frame is plain data, non-digit bytes are skipped; bad header rejects it
      f = '0;
      f[smfr_pkg::POS_HDR1] = smfr_pkg::BYTE_HDR1;
      f[smfr_pkg::POS_MODE] = smfr_pkg::BYTE_DATA_READY;
      f[smfr_pkg::POS_DIGIT_FIRST] = 8'h0a;
      f[smfr_pkg::POS_DIGIT_FIRST+1] = 8'hff;
      f[smfr_pkg::POS_DIGIT_FIRST+3] = 8'h05;
      f[smfr_pkg::POS_DIGIT_LAST] = 8'h07;
      f[smfr_pkg::POS_MEAS] = smfr_pkg::BYTE_MEAS;
      queue_frame(f, 8'h00);
      // random part, with stray bytes between frames now and then
      while (rx_plan.size() < PLAN_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) rx_plan.push_back(8'($urandom_range(0, 255)));
         end
         plan_random_frame();
      end
   endtask

   // sender: bursts of random length with random gaps
   task automatic send_plan();
      int burst_left;
      burst_left = $urandom_range(1, 40);
      foreach (rx_plan[i]) begin
         req_bus.valid <= 1'b1;
         req_bus.rx_byte <= rx_plan[i];
         do @(posedge clock); while (!req_bus.ready);
         burst_left--;
         if (burst_left == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(1, 40);
         end
      end
      req_bus.valid <= 1'b0;
   endtask

   // receiver: stall patterns of random length, plus one long hold-off
   initial begin
      rx_pattern_type pattern;
      int             stretch;
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && rx_transfers >= HOLD_AFTER) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_done = 1'b1;
         end else begin
            pattern = rx_pattern_type'($urandom_range(0, 3));
            stretch = $urandom_range(5, 60);
            repeat (stretch) begin
               case (pattern)
                  RX_STEADY: rsp_bus.ready <= 1'b1;
                  RX_HALF:   rsp_bus.ready <= ($urandom_range(0, 1) == 1);
                  RX_SPARSE: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
                  default:   rsp_bus.ready <= ~rsp_bus.ready;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // transfers on both channels go to the scoreboard
   always @(posedge clock) begin
      smfr_pkg::rsp_data_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            tracker.note_rx_byte(req_bus.rx_byte);
            rx_transfers++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.kind = smfr_pkg::kind_type'(rsp_bus.kind);
            got.tx_byte = rsp_bus.tx_byte;
            got.level_tenths = rsp_bus.level_tenths;
            got.hold = rsp_bus.hold;
            got.freq_weight = rsp_bus.freq_weight;
            got.time_weight = rsp_bus.time_weight;
            got.long_term_avg = rsp_bus.long_term_avg;
            got.over_alarm = rsp_bus.over_alarm;
            got.error_code = smfr_pkg::err_type'(rsp_bus.error_code);
            tracker.check_result(got);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // reset, stimulus, drain and verdict
   initial begin
      tracker = new();
      req_bus.valid <= 1'b0;
      req_bus.rx_byte <= 8'h00;
      build_plan();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      send_plan();
      // let the scoreboard note the last byte transfer before draining
      @(posedge clock);
      while (tracker.expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
